FILE: rtl/fism_pkg.sv
// shared types and constants for the frame interval stutter monitor
package fism_pkg;

    localparam int unsigned FPS_W       = 10;
    localparam int unsigned US_PER_SEC  = 1000000;
    localparam int unsigned DEFAULT_FPS = 60;
    localparam int unsigned SCORE_FULL  = 25600;
    localparam int unsigned HITCH_WT    = 128000;
    localparam int unsigned EXP_W       = 20;
    localparam int unsigned LIMIT_W     = 21;

    typedef enum logic [1:0] {
        MODE_RECORD   = 2'd0,
        MODE_SNAPSHOT = 2'd1,
        MODE_CLEAR    = 2'd2
    } t_mode;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV_E,
        ST_WALK,
        ST_DIV_AVG,
        ST_DIV_SCORE,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic [1:0]  mode;
        logic [31:0] interval;
    } t_in_req;

    typedef struct packed {
        logic [9:0]  sample_count;
        logic [9:0]  hitch_count;
        logic [39:0] average_q8;
        logic [31:0] maximum;
        logic [14:0] score_q8;
        logic [9:0]  rate_echo;
    } t_out_rsp;

    typedef struct packed {
        logic done;
        logic busy;
    } t_div_status;

endpackage

FILE: rtl/fism_store.sv
// interval memory, one write port and one registered read port
module fism_store
    import fism_pkg::*;
#(
    parameter int unsigned DEPTH = 600,
    parameter int unsigned AW    = 10
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [31:0]   i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [31:0]   o_rdata
);

    logic [31:0] r_mem [DEPTH];
    logic [31:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/fism_div.sv
// iterative restoring divider, one quotient bit per cycle
module fism_div
    import fism_pkg::*;
#(
    parameter int unsigned DVD_W = 50,
    parameter int unsigned DVS_W = 10
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [DVD_W-1:0] i_dividend,
    input  logic [DVS_W-1:0] i_divisor,
    output t_div_status      o_status,
    output logic [DVD_W-1:0] o_quot
);

    localparam int unsigned CW = $clog2(DVD_W + 1);

    logic             r_busy;
    logic             r_done;
    logic [CW-1:0]    r_cnt;
    logic [DVS_W:0]   r_rem;
    logic [DVS_W-1:0] r_dvs;
    logic [DVD_W-1:0] r_quo;
    logic [DVS_W:0]   trial;
    logic             fits;

    always_comb begin
        trial = {r_rem[DVS_W-1:0], r_quo[DVD_W-1]};
        fits  = trial >= {1'b0, r_dvs};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= CW'(DVD_W);
        end else if (r_busy) begin
            r_cnt <= r_cnt - CW'(1);
            if (r_cnt == CW'(1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end else begin
            r_done <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_rem <= fits ? (trial - {1'b0, r_dvs}) : trial;
            r_quo <= {r_quo[DVD_W-2:0], fits};
        end
    end

    assign o_status = '{done: r_done, busy: r_busy};
    assign o_quot   = r_quo;

endmodule

FILE: rtl/frame_interval_stutter_monitor.sv
// top level of the frame interval stutter monitor
// Record and clear requests are taken one per cycle; a record writes the interval memory
// at the ring slot and a full window overwrites its oldest entry. A snapshot request
// stalls the input until its result is loaded into the output register. One shared
// bit-serial divider of DVD_W = 40 + clog2(WINDOW_DEPTH+1) bits (50 at the default depth)
// first derives the hitch threshold from frame_rate, the window is then read from memory
// one entry per cycle, and the same divider produces the average and the score. An empty
// window skips the last two divisions. The result waits in an output register while new
// requests are already accepted.
module frame_interval_stutter_monitor
    import fism_pkg::*;
#(
    parameter int unsigned WINDOW_DEPTH = 600
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [FPS_W-1:0] i_cfg_data,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  t_in_req          i_in_data,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output t_out_rsp         o_out_data
);

    localparam int unsigned AW    = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(WINDOW_DEPTH + 1);
    localparam int unsigned SUM_W = 32 + CNT_W;
    localparam int unsigned DVD_W = SUM_W + 8;
    localparam int unsigned DVS_W = (CNT_W > FPS_W) ? CNT_W : FPS_W;
    localparam int unsigned SC_W  = CNT_W + 17;

    t_state           r_state;
    t_state           n_state;
    logic [FPS_W-1:0] r_frame_rate;
    logic [AW-1:0]    r_wr_slot;
    logic [CNT_W-1:0] r_fill;
    logic [CNT_W-1:0] r_rd_cnt;
    logic             r_rd_pend;
    logic [SUM_W-1:0] r_sum;
    logic [31:0]      r_max;
    logic [CNT_W-1:0] r_hits;
    logic [LIMIT_W-1:0] r_limit;
    logic [39:0]      r_avg;
    logic [14:0]      r_score;
    logic [SC_W-1:0]  r_pos;
    logic [SC_W-1:0]  r_neg;
    logic             r_out_valid;
    t_out_rsp         r_out_data;

    logic             in_acc;
    logic             rec_acc;
    logic             snap_acc;
    logic             clr_acc;
    logic             walk_end;
    logic             out_free;
    logic [FPS_W-1:0] fps_eff;
    logic [SC_W-1:0]  diff;
    logic             div_start;
    logic [DVD_W-1:0] div_dividend;
    logic [DVS_W-1:0] div_divisor;
    t_div_status      div_status;
    logic [DVD_W-1:0] div_quot;
    logic [31:0]      rd_data;
    logic [CNT_W+9:0] fill_ext;
    logic [CNT_W+9:0] hits_ext;

    assign o_in_stall = (r_state != ST_IDLE);
    assign in_acc     = i_in_valid && !o_in_stall;
    assign rec_acc    = in_acc && (i_in_data.mode == MODE_RECORD);
    assign snap_acc   = in_acc && (i_in_data.mode == MODE_SNAPSHOT);
    assign clr_acc    = in_acc && (i_in_data.mode == MODE_CLEAR);
    assign walk_end   = (r_rd_cnt == r_fill) && !r_rd_pend;
    assign out_free   = !r_out_valid || !i_out_stall;
    assign fps_eff    = (r_frame_rate == '0) ? FPS_W'(DEFAULT_FPS) : r_frame_rate;
    assign diff       = (r_pos > r_neg) ? (r_pos - r_neg) : '0;
    assign fill_ext   = {10'd0, r_fill};
    assign hits_ext   = {10'd0, r_hits};

    fism_store #(
        .DEPTH (WINDOW_DEPTH),
        .AW    (AW)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (rec_acc),
        .i_waddr (r_wr_slot),
        .i_wdata (i_in_data.interval),
        .i_raddr (r_rd_cnt[AW-1:0]),
        .o_rdata (rd_data)
    );

    fism_div #(
        .DVD_W (DVD_W),
        .DVS_W (DVS_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_status   (div_status),
        .o_quot     (div_quot)
    );

    always_comb begin
        div_start = 1'b0;
        unique case (r_state)
            ST_IDLE:    div_start = snap_acc;
            ST_WALK:    div_start = walk_end && (r_fill != '0);
            ST_DIV_AVG: div_start = div_status.done;
            default:    div_start = 1'b0;
        endcase
    end

    always_comb begin
        unique case (r_state)
            ST_IDLE: begin
                div_dividend = DVD_W'(US_PER_SEC);
                div_divisor  = DVS_W'(fps_eff);
            end
            ST_WALK: begin
                div_dividend = {r_sum, 8'd0};
                div_divisor  = DVS_W'(r_fill);
            end
            default: begin
                div_dividend = DVD_W'(diff);
                div_divisor  = DVS_W'(r_fill);
            end
        endcase
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (snap_acc) n_state = ST_DIV_E;
            end
            ST_DIV_E: begin
                if (div_status.done) n_state = ST_WALK;
            end
            ST_WALK: begin
                if (walk_end) n_state = (r_fill == '0) ? ST_DONE : ST_DIV_AVG;
            end
            ST_DIV_AVG: begin
                if (div_status.done) n_state = ST_DIV_SCORE;
            end
            ST_DIV_SCORE: begin
                if (div_status.done) n_state = ST_DONE;
            end
            ST_DONE: begin
                if (out_free) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // window control and configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_rate <= '0;
            r_wr_slot    <= '0;
            r_fill       <= '0;
        end else begin
            if (i_cfg_we) begin
                r_frame_rate <= i_cfg_data;
            end
            if (rec_acc) begin
                r_wr_slot <= (r_wr_slot == AW'(WINDOW_DEPTH - 1)) ? '0 : r_wr_slot + AW'(1);
                if (r_fill != CNT_W'(WINDOW_DEPTH)) begin
                    r_fill <= r_fill + CNT_W'(1);
                end
            end else if (clr_acc) begin
                r_wr_slot <= '0;
                r_fill    <= '0;
            end
        end
    end

    // window walk
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_pend <= 1'b0;
            r_rd_cnt  <= '0;
        end else if (snap_acc) begin
            r_rd_pend <= 1'b0;
            r_rd_cnt  <= '0;
        end else if (r_state == ST_WALK) begin
            r_rd_pend <= (r_rd_cnt != r_fill);
            if (r_rd_cnt != r_fill) begin
                r_rd_cnt <= r_rd_cnt + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (snap_acc) begin
            r_sum   <= '0;
            r_max   <= '0;
            r_hits  <= '0;
            r_avg   <= '0;
            r_score <= '0;
        end else begin
            if (r_state == ST_WALK && r_rd_pend) begin
                r_sum <= r_sum + SUM_W'(rd_data);
                if (rd_data > r_max) begin
                    r_max <= rd_data;
                end
                if (rd_data > 32'(r_limit)) begin
                    r_hits <= r_hits + CNT_W'(1);
                end
            end
            if (r_state == ST_DIV_E && div_status.done) begin
                r_limit <= LIMIT_W'(div_quot[EXP_W-1:0]) + LIMIT_W'(div_quot[EXP_W-1:1]);
            end
            if (r_state == ST_DIV_AVG && div_status.done) begin
                r_avg <= div_quot[39:0];
            end
            if (r_state == ST_DIV_SCORE && div_status.done) begin
                r_score <= (div_quot > DVD_W'(SCORE_FULL)) ? 15'(SCORE_FULL)
                                                            : div_quot[14:0];
            end
        end
        r_pos <= SC_W'(r_fill) * SC_W'(SCORE_FULL);
        r_neg <= SC_W'(r_hits) * SC_W'(HITCH_WT);
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == ST_DONE && out_free) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_DONE && out_free) begin
            r_out_data.sample_count <= fill_ext[9:0];
            r_out_data.hitch_count  <= hits_ext[9:0];
            r_out_data.average_q8   <= r_avg;
            r_out_data.maximum      <= r_max;
            r_out_data.score_q8     <= r_score;
            r_out_data.rate_echo    <= r_frame_rate;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= CNT_W'(WINDOW_DEPTH))
        else $error("fill count above window depth");

    a_slot_tracks_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_fill != CNT_W'(WINDOW_DEPTH)) |-> (CNT_W'(r_wr_slot) == r_fill))
        else $error("write slot out of step with fill count");

    a_snap_stalls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        snap_acc |=> o_in_stall)
        else $error("snapshot did not stall the input");

    a_out_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == ST_DONE))
        else $error("result loaded outside done state");

    a_walk_no_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_WALK) |-> !div_status.busy)
        else $error("divider busy during window walk");

endmodule

FILE: test/frame_interval_stutter_monitor_tb.sv
// self-checking testbench for the frame interval stutter monitor: random and directed requests
module frame_interval_stutter_monitor_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import fism_pkg::*;

    localparam int unsigned WINDOW_DEPTH = 600;
    localparam int unsigned CYCLE_LIMIT  = 6000000;
    localparam int unsigned PHASE_GAP    = 50;
    localparam int unsigned TAIL_WAIT    = 1000;
    localparam int unsigned LONG_HOLD    = 3000;
    localparam int unsigned IDLE_HEAVY   = 72;
    localparam int unsigned IDLE_LIGHT   = 13;
    localparam logic [1:0]  MODE_UNUSED  = 2'd3;

    typedef enum {PACE_NONE, PACE_SEND, PACE_RECV, PACE_BOTH} t_pace;

    logic             clk       = 1'b0;
    logic             rst_n     = 1'b0;
    logic             cfg_we    = 1'b0;
    logic [FPS_W-1:0] cfg_data  = '0;
    logic             in_valid  = 1'b0;
    logic             in_stall;
    t_in_req          in_req    = '0;
    logic             out_valid;
    logic             out_stall = 1'b0;
    t_out_rsp         out_rsp;

    // predictor state
    logic [31:0]      window_us [WINDOW_DEPTH];
    int unsigned      wr_slot   = 0;
    int unsigned      fill_cnt  = 0;
    logic [FPS_W-1:0] rate_reg  = '0;

    t_in_req          req_q [$];
    t_out_rsp         snap_q [$];

    int unsigned      send_pct     = 0;
    int unsigned      recv_pct     = 0;
    int unsigned      hold_len     = 0;
    int unsigned      hold_id      = 0;
    int unsigned      hold_seen    = 0;
    int unsigned      hold_left    = 0;
    int unsigned      cycle_cnt    = 0;
    int unsigned      fail_cnt     = 0;
    int unsigned      accepted_cnt = 0;
    int unsigned      checked_cnt  = 0;
    int unsigned      full_cnt     = 0;
    int unsigned      rate_writes  = 0;

    frame_interval_stutter_monitor #(
        .WINDOW_DEPTH(WINDOW_DEPTH)
    ) dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_data (cfg_data),
        .i_in_valid (in_valid),
        .o_in_stall (in_stall),
        .i_in_data  (in_req),
        .o_out_valid(out_valid),
        .i_out_stall(out_stall),
        .o_out_data (out_rsp)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic logic [63:0] hitch_limit();
        logic [31:0] fps;
        logic [31:0] exp_us;
        fps    = (rate_reg == 0) ? DEFAULT_FPS : 32'(rate_reg);
        exp_us = US_PER_SEC / fps;
        return 64'(exp_us) + 64'(exp_us / 2);
    endfunction

    function automatic t_out_rsp snapshot_stats();
        t_out_rsp    r;
        logic [63:0] lim;
        logic [63:0] n;
        logic [63:0] sum;
        logic [63:0] hitches;
        logic [63:0] avg;
        logic [63:0] score;
        logic [63:0] pos;
        logic [63:0] neg;
        logic [31:0] peak;
        lim     = hitch_limit();
        n       = 64'(fill_cnt);
        sum     = '0;
        hitches = '0;
        avg     = '0;
        score   = '0;
        peak    = '0;
        for (int unsigned i = 0; i < fill_cnt; i++) begin
            sum += 64'(window_us[i]);
            if (window_us[i] > peak) peak = window_us[i];
            if (64'(window_us[i]) > lim) hitches++;
        end
        if (n != 0) begin
            pos   = 64'(SCORE_FULL) * n;
            neg   = 64'(HITCH_WT) * hitches;
            avg   = (sum * 256) / n;
            score = (pos > neg) ? (pos - neg) / n : '0;
            if (score > 64'(SCORE_FULL)) score = 64'(SCORE_FULL);
        end
        r.sample_count = n[9:0];
        r.hitch_count  = hitches[9:0];
        r.average_q8   = avg[39:0];
        r.maximum      = peak;
        r.score_q8     = score[14:0];
        r.rate_echo    = rate_reg;
        return r;
    endfunction

    function automatic void apply_request(t_in_req r);
        case (r.mode)
            MODE_RECORD: begin
                window_us[wr_slot] = r.interval;
                wr_slot = (wr_slot + 1 >= WINDOW_DEPTH) ? 0 : wr_slot + 1;
                if (fill_cnt < WINDOW_DEPTH) fill_cnt++;
            end
            MODE_CLEAR: begin
                wr_slot  = 0;
                fill_cnt = 0;
            end
            MODE_SNAPSHOT: begin
                snap_q.insert(snap_q.size(), snapshot_stats());
            end
            default: begin
            end
        endcase
    endfunction

    task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
        if (want !== got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fail_cnt++;
        end
    endtask

    // request driver
    always @(posedge clk) begin : drive_proc
        logic offer;
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && !in_stall) begin
                apply_request(in_req);
                accepted_cnt++;
            end
            if (!in_valid || !in_stall) begin
                offer = (req_q.size() != 0) && ($urandom_range(99) >= send_pct);
                in_valid <= offer;
                if (offer) begin
                    in_req <= req_q[0];
                    req_q.delete(0);
                end
            end
        end
    end

    // result monitor
    always @(posedge clk) begin : watch_proc
        t_out_rsp want;
        if (!rst_n) begin
            out_stall <= 1'b0;
        end else begin
            if (out_valid && !out_stall) begin
                if (snap_q.size() == 0) begin
                    $error("result with no snapshot pending");
                    fail_cnt++;
                end else begin
                    want = snap_q[0];
                    snap_q.delete(0);
                    check_field("sample_count", want.sample_count, out_rsp.sample_count);
                    check_field("hitch_count", want.hitch_count, out_rsp.hitch_count);
                    check_field("average_q8", want.average_q8, out_rsp.average_q8);
                    check_field("maximum", want.maximum, out_rsp.maximum);
                    check_field("score_q8", want.score_q8, out_rsp.score_q8);
                    check_field("rate_echo", want.rate_echo, out_rsp.rate_echo);
                    if (want.sample_count == WINDOW_DEPTH) full_cnt++;
                    checked_cnt++;
                end
            end
            if (hold_id != hold_seen) begin
                hold_seen <= hold_id;
                hold_left <= hold_len;
                out_stall <= 1'b1;
            end else if (hold_left != 0) begin
                hold_left <= hold_left - 1;
                out_stall <= 1'b1;
            end else begin
                out_stall <= ($urandom_range(99) < recv_pct);
            end
        end
    end

    always @(posedge clk) begin : limit_proc
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("frame_interval_stutter_monitor_tb failed");
            $finish;
        end
    end

    task automatic send(logic [1:0] mode, logic [31:0] value);
        t_in_req r;
        r.mode     = mode;
        r.interval = value;
        req_q.insert(req_q.size(), r);
    endtask

    function automatic logic [31:0] rand_interval();
        logic [31:0] lim;
        int unsigned pick;
        lim  = 32'(hitch_limit());
        pick = $urandom_range(99);
        if (pick < 70) return $urandom_range(lim);
        if (pick < 78) return lim;
        if (pick < 86) return $urandom_range(lim + 1, 2 * lim);
        if (pick < 90) return 32'h0000_0000;
        if (pick < 93) return 32'hFFFF_FFFF;
        return $urandom();
    endfunction

    task automatic push_mix(int unsigned count, int unsigned snap_pct, int unsigned clear_pct);
        int unsigned pick;
        for (int unsigned i = 0; i < count; i++) begin
            pick = $urandom_range(99);
            if (pick < snap_pct)
                send(MODE_SNAPSHOT, $urandom());
            else if (pick < snap_pct + clear_pct)
                send(MODE_CLEAR, $urandom());
            else if (pick < snap_pct + clear_pct + 2)
                send(MODE_UNUSED, $urandom());
            else
                send(MODE_RECORD, rand_interval());
        end
    endtask

    // sampled away from the rising edge so the driver and monitor updates have landed
    task automatic settle(int unsigned extra);
        do @(negedge clk); while (req_q.size() != 0 || in_valid || snap_q.size() != 0);
        repeat (extra) @(posedge clk);
    endtask

    task automatic set_rate(logic [FPS_W-1:0] value);
        @(posedge clk);
        cfg_we   <= 1'b1;
        cfg_data <= value;
        @(posedge clk);
        cfg_we   <= 1'b0;
        rate_reg = value;
        rate_writes++;
    endtask

    task automatic set_pace(t_pace p);
        @(posedge clk);
        send_pct <= (p == PACE_SEND) ? IDLE_HEAVY : (p == PACE_BOTH) ? IDLE_LIGHT : 0;
        recv_pct <= (p == PACE_RECV) ? IDLE_HEAVY : (p == PACE_BOTH) ? IDLE_LIGHT : 0;
    endtask

    task automatic hold_receiver(int unsigned cycles);
        @(posedge clk);
        hold_len <= cycles;
        hold_id  <= hold_id + 1;
    endtask

    initial begin : stim_proc
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty window, field extremes, threshold edge, unused mode, clear
        set_rate(10'd0);
        set_pace(PACE_NONE);
        send(MODE_SNAPSHOT, 32'h0000_0000);
        send(MODE_RECORD, 32'h0000_0000);
        send(MODE_RECORD, 32'hFFFF_FFFF);
        send(MODE_RECORD, 32'd24999);
        send(MODE_RECORD, 32'd25000);
        send(MODE_SNAPSHOT, 32'hFFFF_FFFF);
        send(MODE_UNUSED, 32'hA5A5_5A5A);
        send(MODE_SNAPSHOT, 32'h0000_0000);
        send(MODE_CLEAR, 32'hFFFF_FFFF);
        send(MODE_SNAPSHOT, 32'h0000_0000);
        send(MODE_RECORD, 32'd16666);
        send(MODE_RECORD, 32'd1);
        send(MODE_RECORD, 32'h5A5A_A5A5);
        send(MODE_SNAPSHOT, 32'h0000_0000);
        send(MODE_SNAPSHOT, 32'h0000_0000);
        send(MODE_CLEAR, 32'h0000_0000);
        send(MODE_UNUSED, 32'h0000_0000);
        send(MODE_SNAPSHOT, 32'h0000_0000);
        settle(PHASE_GAP);

        set_rate(10'd1000);
        send(MODE_RECORD, 32'd1500);
        send(MODE_RECORD, 32'd1501);
        send(MODE_SNAPSHOT, 32'h0000_0000);
        push_mix(150, 8, 4);
        settle(PHASE_GAP);

        set_rate(10'd1);
        set_pace(PACE_SEND);
        push_mix(150, 8, 4);
        settle(PHASE_GAP);

        set_rate(10'($urandom_range(2, 999)));
        set_pace(PACE_RECV);
        push_mix(150, 8, 4);
        settle(PHASE_GAP);

        // fill past the window depth so the oldest entries get overwritten
        set_rate(10'd60);
        set_pace(PACE_BOTH);
        send(MODE_CLEAR, $urandom());
        push_mix(700, 3, 0);
        for (int i = 0; i < 10; i++) begin
            send(MODE_RECORD, rand_interval());
            send(MODE_SNAPSHOT, $urandom());
        end
        settle(PHASE_GAP);

        // long receiver hold while snapshots pile up
        set_rate(10'($urandom_range(1000)));
        set_pace(PACE_NONE);
        send(MODE_CLEAR, $urandom());
        hold_receiver(LONG_HOLD);
        push_mix(120, 25, 0);
        settle(0);
        set_pace(PACE_BOTH);
        push_mix(60, 20, 0);
        settle(TAIL_WAIT);

        $display("accepted %0d requests, checked %0d snapshots, %0d of them on a full window",
                 accepted_cnt, checked_cnt, full_cnt);
        $display("frame rate written %0d times, including 0, 1 and 1000", rate_writes);
        if (fail_cnt == 0) begin
            $display("frame_interval_stutter_monitor_tb passed");
        end else begin
            $display("frame_interval_stutter_monitor_tb failed");
        end
        $finish;
    end

endmodule
